// File: rtl/core/pcss_pkg.sv
// Shared constants, types and glyph lookup for the period capture display.
package pcss_pkg;

  // Period and configuration widths
  localparam int unsigned PERIOD_WIDTH = 16;
  localparam int unsigned CFG_W        = 4;
  localparam logic [CFG_W-1:0] IGNORED_LOW_BITS_RESET = CFG_W'(3);

  // Compare mask is built over the full shift range of the config field
  localparam int unsigned LOW_W  = 1 << CFG_W;
  localparam int unsigned MASK_W = (PERIOD_WIDTH > LOW_W) ? PERIOD_WIDTH : LOW_W;

  // Decimal split
  localparam int unsigned DIGIT_COUNT = 6;
  localparam int unsigned SEG_W       = 7;
  localparam int unsigned BCD_W       = 4;
  localparam int unsigned GLYPH_COUNT = 10;

  // Exact reciprocal divide by 10^k for any value below 2^PERIOD_WIDTH:
  // q = (v * RECIP[k]) >> DEC_SHIFT[k], RECIP[k] = floor(2^shift / 10^k) + 1
  localparam int unsigned RECIP_W = PERIOD_WIDTH + 1;
  localparam int unsigned PROD_W  = PERIOD_WIDTH + RECIP_W;

  localparam logic [63:0] DEC_POW [DIGIT_COUNT+1] = '{
    64'd1, 64'd10, 64'd100, 64'd1000, 64'd10000, 64'd100000, 64'd1000000
  };

  localparam int unsigned DEC_SHIFT [DIGIT_COUNT+1] = '{
    PERIOD_WIDTH + $clog2(1),     PERIOD_WIDTH + $clog2(10),
    PERIOD_WIDTH + $clog2(100),   PERIOD_WIDTH + $clog2(1000),
    PERIOD_WIDTH + $clog2(10000), PERIOD_WIDTH + $clog2(100000),
    PERIOD_WIDTH + $clog2(1000000)
  };

  localparam logic [63:0] RECIP [DIGIT_COUNT+1] = '{
    ((64'd1 << DEC_SHIFT[0]) / DEC_POW[0]) + 64'd1,
    ((64'd1 << DEC_SHIFT[1]) / DEC_POW[1]) + 64'd1,
    ((64'd1 << DEC_SHIFT[2]) / DEC_POW[2]) + 64'd1,
    ((64'd1 << DEC_SHIFT[3]) / DEC_POW[3]) + 64'd1,
    ((64'd1 << DEC_SHIFT[4]) / DEC_POW[4]) + 64'd1,
    ((64'd1 << DEC_SHIFT[5]) / DEC_POW[5]) + 64'd1,
    ((64'd1 << DEC_SHIFT[6]) / DEC_POW[6]) + 64'd1
  };

  // Common-cathode glyphs, bit0 = segment a .. bit6 = segment g
  localparam logic [SEG_W-1:0] SEG_GLYPH [GLYPH_COUNT] = '{
    7'h3f, 7'h06, 7'h5b, 7'h4f, 7'h66, 7'h6d, 7'h7d, 7'h07, 7'h7f, 7'h6f
  };

  // Held period word passed from the hold stage to the decimal stages
  typedef struct packed {
    logic [PERIOD_WIDTH-1:0] period;
    logic                    changed;
  } pcss_held_t;

  // Digit to glyph; codes above nine blank the digit
  function automatic logic [SEG_W-1:0] seg_of_digit(input logic [BCD_W-1:0] digit);
    logic [SEG_W-1:0] seg;
    if (digit < BCD_W'(GLYPH_COUNT)) begin
      seg = SEG_GLYPH[digit];
    end else begin
      seg = '0;
    end
    return seg;
  endfunction

endpackage

// File: rtl/core/pcss_if.sv
// Valid/ready channel interfaces for capture input words and display result words.
interface pcss_in_if;
  import pcss_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [PERIOD_WIDTH-1:0] captured_period;

  modport source (output valid, output captured_period, input ready);
  modport sink   (input valid, input captured_period, output ready);
endinterface

interface pcss_out_if;
  import pcss_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [SEG_W-1:0]        digit0_segments;
  logic [SEG_W-1:0]        digit1_segments;
  logic [SEG_W-1:0]        digit2_segments;
  logic [SEG_W-1:0]        digit3_segments;
  logic [SEG_W-1:0]        digit4_segments;
  logic [SEG_W-1:0]        digit5_segments;
  logic [PERIOD_WIDTH-1:0] shown_period;
  logic                    was_updated;

  modport source (
    output valid, output digit0_segments, output digit1_segments, output digit2_segments,
    output digit3_segments, output digit4_segments, output digit5_segments,
    output shown_period, output was_updated, input ready
  );
  modport sink (
    input valid, input digit0_segments, input digit1_segments, input digit2_segments,
    input digit3_segments, input digit4_segments, input digit5_segments,
    input shown_period, input was_updated, output ready
  );
endinterface

// File: rtl/core/period_capture_seven_segment.sv
// Top level: period capture hold logic and seven-segment decimal display words.
//
// Each captured period word is compared with the held period with the low
// ignored_low_bits bits masked off (reset value 3); on a difference the held
// period takes the new capture. Every capture gives one result word: the held
// period, its six decimal digits as common-cathode glyphs (units first, bit0 =
// segment a) and a flag telling whether this capture replaced it. One word is
// accepted per clock cycle unless out_o.ready holds the pipe; a result passes
// through an input register, the hold-compare register, a register of
// reciprocal-multiply quotients and the glyph output register. The held period
// compare feeds its update directly, which is what lets captures follow back
// to back. Write the configuration register only while no word is in flight.
module period_capture_seven_segment (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [pcss_pkg::CFG_W-1:0] cfg_wdata_i,
  pcss_in_if.sink                    in_i,
  pcss_out_if.source                 out_o
);
  import pcss_pkg::*;

  logic       held_valid;
  logic       held_ready;
  pcss_held_t held;

  // Compare and hold
  pcss_hold u_hold (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_i         (in_i),
    .held_valid_o (held_valid),
    .held_ready_i (held_ready),
    .held_o       (held)
  );

  // Decimal digits and glyphs
  pcss_decimal u_decimal (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .held_valid_i (held_valid),
    .held_ready_o (held_ready),
    .held_i       (held),
    .out_o        (out_o)
  );

endmodule

// File: rtl/core/pcss_hold.sv
// Input register, ignored-bits config register and held period update stage.
module pcss_hold (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [pcss_pkg::CFG_W-1:0]           cfg_wdata_i,
  pcss_in_if.sink                              in_i,
  output logic                                 held_valid_o,
  input  logic                                 held_ready_i,
  output pcss_pkg::pcss_held_t                 held_o
);
  import pcss_pkg::*;

  logic [CFG_W-1:0]        ign_q;
  logic                    cap_valid_q, cap_valid_d;
  logic [PERIOD_WIDTH-1:0] cap_q;
  logic                    held_valid_q, held_valid_d;
  logic [PERIOD_WIDTH-1:0] held_q, held_d;
  logic                    changed_q;
  logic                    changed;
  logic                    in_take;
  logic                    held_free;
  logic                    held_load;
  logic [LOW_W:0]          low_ones;
  logic [MASK_W-1:0]       mask_wide;
  logic [PERIOD_WIDTH-1:0] cmp_mask;

  // Handshake: each register frees up when its word moves on
  assign held_free  = !held_valid_q || held_ready_i;
  assign in_i.ready = !cap_valid_q || held_free;
  assign in_take    = in_i.valid && in_i.ready;
  assign held_load  = cap_valid_q && held_free;

  // Compare mask: clear the ignored low bits; the top period bit is always compared
  always_comb begin
    low_ones  = ((LOW_W+1)'(1) << ign_q) - (LOW_W+1)'(1);
    mask_wide = ~MASK_W'(low_ones);
    cmp_mask  = mask_wide[PERIOD_WIDTH-1:0];
  end

  assign changed = (cap_q & cmp_mask) != (held_q & cmp_mask);
  assign held_d  = changed ? cap_q : held_q;

  always_comb begin
    cap_valid_d = cap_valid_q;
    if (in_take) begin
      cap_valid_d = 1'b1;
    end else if (held_free) begin
      cap_valid_d = 1'b0;
    end
    held_valid_d = held_valid_q;
    if (held_load) begin
      held_valid_d = 1'b1;
    end else if (held_ready_i) begin
      held_valid_d = 1'b0;
    end
  end

  // Control and held state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ign_q        <= IGNORED_LOW_BITS_RESET;
      cap_valid_q  <= 1'b0;
      held_valid_q <= 1'b0;
      held_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        ign_q <= cfg_wdata_i;
      end
      cap_valid_q  <= cap_valid_d;
      held_valid_q <= held_valid_d;
      if (held_load) begin
        held_q <= held_d;
      end
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      cap_q <= in_i.captured_period;
    end
    if (held_load) begin
      changed_q <= changed;
    end
  end

  assign held_valid_o   = held_valid_q;
  assign held_o.period  = held_q;
  assign held_o.changed = changed_q;

endmodule

// File: rtl/core/pcss_decimal.sv
// Decimal split by reciprocal multiplies, then digit extraction and glyph output register.
module pcss_decimal (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 held_valid_i,
  output logic                 held_ready_o,
  input  pcss_pkg::pcss_held_t held_i,
  pcss_out_if.source           out_o
);
  import pcss_pkg::*;

  logic                    quot_valid_q, quot_valid_d;
  logic [PERIOD_WIDTH-1:0] quot_d [DIGIT_COUNT+1];
  logic [PERIOD_WIDTH-1:0] quot_q [DIGIT_COUNT+1];
  logic                    changed_q;
  logic                    out_valid_q, out_valid_d;
  logic [SEG_W-1:0]        seg_d [DIGIT_COUNT];
  logic [SEG_W-1:0]        seg_q [DIGIT_COUNT];
  logic [PERIOD_WIDTH-1:0] shown_q;
  logic                    updated_q;
  logic                    out_free;
  logic                    quot_load;
  logic                    out_load;

  assign out_free     = !out_valid_q || out_o.ready;
  assign held_ready_o = !quot_valid_q || out_free;
  assign quot_load    = held_valid_i && held_ready_o;
  assign out_load     = quot_valid_q && out_free;

  // Quotients by 10^k, each an independent constant multiply and shift
  assign quot_d[0] = held_i.period;
  for (genvar k = 1; k <= DIGIT_COUNT; k++) begin : g_quot
    logic [PROD_W-1:0] prod;
    assign prod      = PROD_W'(held_i.period) * PROD_W'(RECIP[k][RECIP_W-1:0]);
    assign quot_d[k] = PERIOD_WIDTH'(prod >> DEC_SHIFT[k]);
  end

  // Digit k = q_k - 10 * q_(k+1), always 0..9, so four low bits suffice
  always_comb begin
    for (int k = 0; k < DIGIT_COUNT; k++) begin
      seg_d[k] = seg_of_digit(BCD_W'(quot_q[k] - ((quot_q[k+1] << 3) + (quot_q[k+1] << 1))));
    end
  end

  always_comb begin
    quot_valid_d = quot_valid_q;
    if (quot_load) begin
      quot_valid_d = 1'b1;
    end else if (out_free) begin
      quot_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quot_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      quot_valid_q <= quot_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (quot_load) begin
      quot_q    <= quot_d;
      changed_q <= held_i.changed;
    end
    if (out_load) begin
      seg_q     <= seg_d;
      shown_q   <= quot_q[0];
      updated_q <= changed_q;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.digit0_segments = seg_q[0];
  assign out_o.digit1_segments = seg_q[1];
  assign out_o.digit2_segments = seg_q[2];
  assign out_o.digit3_segments = seg_q[3];
  assign out_o.digit4_segments = seg_q[4];
  assign out_o.digit5_segments = seg_q[5];
  assign out_o.shown_period    = shown_q;
  assign out_o.was_updated     = updated_q;

endmodule
